>>> design/btlh_pkg.sv
// Package for the BER tag/length header parser.
// Holds the shared constants, status codes and the result beat type.
// No dependencies.
package btlh_pkg;

   // Default limits on header size
   localparam int MAX_TAG_OCTETS_DEF    = 4;
   localparam int MAX_LENGTH_OCTETS_DEF = 4;

   // Result field widths
   localparam int STATUS_W      = 2;
   localparam int OCTET_W       = 8;
   localparam int TAG_SIZE_W    = 3;
   localparam int LENGTH_SIZE_W = 3;
   localparam int CONTENT_LEN_W = 32;

   // Octet patterns
   localparam logic [OCTET_W-1:0] OCTET_ZERO      = 8'h00;
   localparam logic [OCTET_W-1:0] OCTET_INDEF     = 8'h80;
   localparam logic [4:0]         TAG_NUM_ESCAPE  = 5'h1F;
   localparam logic [6:0]         LEN_COUNT_MASK  = 7'h7F;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_TAG = 2'd1,
      STATUS_BAD_LEN = 2'd2
   } status_type;

   // One result beat
   typedef struct packed {
      status_type                status;
      logic [OCTET_W-1:0]        first_tag_octet;
      logic [TAG_SIZE_W-1:0]     tag_size;
      logic [LENGTH_SIZE_W-1:0]  length_size;
      logic [CONTENT_LEN_W-1:0]  content_length;
      logic                      indefinite;
   } result_type;

endpackage

>>> design/btlh_parser.sv
// Header parse state machine: consumes one octet per accepted beat and
// produces at most one result beat in the same cycle.
// Depends on btlh_pkg.
module btlh_parser #(
   parameter int MAX_TAG_OCTETS    = btlh_pkg::MAX_TAG_OCTETS_DEF,
   parameter int MAX_LENGTH_OCTETS = btlh_pkg::MAX_LENGTH_OCTETS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          beat_accept,
   input  logic [btlh_pkg::OCTET_W-1:0]  header_byte,
   input  logic                          start_req,
   output logic                          result_valid,
   output btlh_pkg::result_type          result
);
   import btlh_pkg::*;

   localparam int TagCntRaw = $clog2(MAX_TAG_OCTETS + 1);
   localparam int TagCntW   = (TagCntRaw > TAG_SIZE_W) ? TagCntRaw : TAG_SIZE_W;
   localparam int LsizeRaw  = $clog2(MAX_LENGTH_OCTETS + 2);
   localparam int LsizeW    = (LsizeRaw > LENGTH_SIZE_W) ? LsizeRaw : LENGTH_SIZE_W;
   localparam int LeftW     = $clog2(MAX_LENGTH_OCTETS + 1);

   typedef enum logic [3:0] {
      PH_IDLE      = 4'b0001,
      PH_TAG_MORE  = 4'b0010,
      PH_LEN_FIRST = 4'b0100,
      PH_LEN_LONG  = 4'b1000
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic [TagCntW-1:0]       tag_cnt_ff, tag_cnt_in;
   logic [OCTET_W-1:0]       first_octet_ff, first_octet_in;
   logic [LeftW-1:0]         len_left_ff, len_left_in;
   logic [LsizeW-1:0]        len_size_ff, len_size_in;
   logic [CONTENT_LEN_W-1:0] len_acc_ff, len_acc_in;

   logic [6:0]               len_count;

   assign len_count = header_byte[6:0] & LEN_COUNT_MASK;

   // Next state and result for the current octet
   always_comb begin
      phase_in       = phase_ff;
      tag_cnt_in     = tag_cnt_ff;
      first_octet_in = first_octet_ff;
      len_left_in    = len_left_ff;
      len_size_in    = len_size_ff;
      len_acc_in     = len_acc_ff;
      result_valid   = 1'b0;
      result         = '0;
      result.status  = STATUS_OK;
      result.first_tag_octet = first_octet_ff;

      if (beat_accept) begin
         if (start_req) begin
            // First tag octet restarts the header
            first_octet_in = header_byte;
            tag_cnt_in     = TagCntW'(1);
            len_left_in    = '0;
            len_size_in    = LsizeW'(1);
            len_acc_in     = '0;
            if (header_byte == OCTET_ZERO) begin
               result_valid           = 1'b1;
               result.status          = STATUS_BAD_TAG;
               result.first_tag_octet = header_byte;
               phase_in               = PH_IDLE;
            end else if (header_byte[4:0] == TAG_NUM_ESCAPE) begin
               phase_in = PH_TAG_MORE;
            end else begin
               phase_in = PH_LEN_FIRST;
            end
         end else begin
            unique case (phase_ff)
               PH_TAG_MORE: begin
                  // Tag continuation octets
                  if (tag_cnt_ff == TagCntW'(MAX_TAG_OCTETS)) begin
                     result_valid  = 1'b1;
                     result.status = STATUS_BAD_TAG;
                     phase_in      = PH_IDLE;
                  end else begin
                     tag_cnt_in = tag_cnt_ff + TagCntW'(1);
                     if (!header_byte[7]) begin
                        phase_in = PH_LEN_FIRST;
                     end
                  end
               end
               PH_LEN_FIRST: begin
                  result.tag_size = tag_cnt_ff[TAG_SIZE_W-1:0];
                  if (!header_byte[7]) begin
                     // Short form
                     len_size_in           = LsizeW'(1);
                     result_valid          = 1'b1;
                     result.length_size    = LENGTH_SIZE_W'(1);
                     result.content_length = CONTENT_LEN_W'(header_byte);
                     phase_in              = PH_IDLE;
                  end else if (header_byte == OCTET_INDEF) begin
                     // Indefinite form
                     len_size_in           = LsizeW'(1);
                     result_valid          = 1'b1;
                     result.length_size    = LENGTH_SIZE_W'(1);
                     result.content_length = '1;
                     result.indefinite     = 1'b1;
                     phase_in              = PH_IDLE;
                  end else if (len_count > 7'(MAX_LENGTH_OCTETS)) begin
                     result_valid  = 1'b1;
                     result.status = STATUS_BAD_LEN;
                     phase_in      = PH_IDLE;
                  end else begin
                     // Long form: count of big-endian octets follows
                     len_left_in = LeftW'(len_count);
                     len_size_in = LsizeW'(len_count) + LsizeW'(1);
                     len_acc_in  = '0;
                     phase_in    = PH_LEN_LONG;
                  end
               end
               PH_LEN_LONG: begin
                  len_acc_in  = {len_acc_ff[CONTENT_LEN_W-OCTET_W-1:0], header_byte};
                  len_left_in = len_left_ff - LeftW'(1);
                  if (len_left_ff == LeftW'(1)) begin
                     result_valid          = 1'b1;
                     result.tag_size       = tag_cnt_ff[TAG_SIZE_W-1:0];
                     result.length_size    = len_size_ff[LENGTH_SIZE_W-1:0];
                     result.content_length = len_acc_in;
                     phase_in              = PH_IDLE;
                  end
               end
               default: begin
                  // Idle: stray octets are dropped
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         tag_cnt_ff     <= '0;
         first_octet_ff <= '0;
         len_left_ff    <= '0;
         len_size_ff    <= LsizeW'(1);
         len_acc_ff     <= '0;
      end else begin
         phase_ff       <= phase_in;
         tag_cnt_ff     <= tag_cnt_in;
         first_octet_ff <= first_octet_in;
         len_left_ff    <= len_left_in;
         len_size_ff    <= len_size_in;
         len_acc_ff     <= len_acc_in;
      end
   end

endmodule

>>> design/btlh_out_buf.sv
// Two-entry result buffer: an output register plus a skid register, so the
// input side keeps taking beats while a result waits downstream.
// Depends on btlh_pkg.
module btlh_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  btlh_pkg::result_type  push_data,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output btlh_pkg::result_type  out_data
);
   import btlh_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       main_free;

   assign main_free = !main_valid_ff || !out_stall;

   // Refill the output register from the skid entry first, keeping order
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_in       = push_data;
            skid_valid_in = push_valid;
         end else begin
            main_in       = push_data;
            main_valid_in = push_valid;
         end
      end else if (push_valid) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

>>> design/ber_tag_length_header_parser.sv
// BER tag/length header parser, top level.
// Depends on btlh_pkg, btlh_parser and btlh_out_buf.
//
// Feed the header one octet per beat, with req_start_req set on the first
// tag octet; a start always abandons any header in progress. One beat is
// taken every cycle unless req_stall is high; the parser handles each octet
// combinationally and writes at most one result into a two-entry output
// buffer when an octet completes the header or reveals an error. req_stall
// rises only when both buffer entries hold results that the consumer has
// not taken. Octets that arrive while no header is open are dropped without
// a result.
module ber_tag_length_header_parser #(
   parameter int MAX_TAG_OCTETS    = btlh_pkg::MAX_TAG_OCTETS_DEF,
   parameter int MAX_LENGTH_OCTETS = btlh_pkg::MAX_LENGTH_OCTETS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [btlh_pkg::OCTET_W-1:0]        req_header_byte,
   input  logic                                req_start_req,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [btlh_pkg::STATUS_W-1:0]       rsp_status,
   output logic [btlh_pkg::OCTET_W-1:0]        rsp_first_tag_octet,
   output logic [btlh_pkg::TAG_SIZE_W-1:0]     rsp_tag_size,
   output logic [btlh_pkg::LENGTH_SIZE_W-1:0]  rsp_length_size,
   output logic [btlh_pkg::CONTENT_LEN_W-1:0]  rsp_content_length,
   output logic                                rsp_indefinite
);
   import btlh_pkg::*;

   logic       beat_accept;
   logic       buf_full;
   logic       res_valid;
   result_type res_data;
   result_type rsp_data;

   assign req_stall   = buf_full;
   assign beat_accept = req_valid && !buf_full;

   btlh_parser #(
      .MAX_TAG_OCTETS    (MAX_TAG_OCTETS),
      .MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .beat_accept  (beat_accept),
      .header_byte  (req_header_byte),
      .start_req    (req_start_req),
      .result_valid (res_valid),
      .result       (res_data)
   );

   btlh_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_data  (res_data),
      .full       (buf_full),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (rsp_data)
   );

   // Unpack the result beat onto the ports
   assign rsp_status          = rsp_data.status;
   assign rsp_first_tag_octet = rsp_data.first_tag_octet;
   assign rsp_tag_size        = rsp_data.tag_size;
   assign rsp_length_size     = rsp_data.length_size;
   assign rsp_content_length  = rsp_data.content_length;
   assign rsp_indefinite      = rsp_data.indefinite;

endmodule

>>> bench/ber_tag_length_header_parser_tb.sv
// Testbench for ber_tag_length_header_parser: directed and random BER headers.
// Depends on btlh_pkg and the ber_tag_length_header_parser RTL.
// Beats are checked against a header decoder kept inside the bench.
`timescale 1ns / 100ps

module ber_tag_length_header_parser_tb;
   import btlh_pkg::*;

   typedef enum logic [1:0] {
      HDR_IDLE,
      HDR_TAG_MORE,
      HDR_LEN_FIRST,
      HDR_LEN_LONG
   } hdr_phase_type;

   localparam int RANDOM_OCTETS = 950;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OCTET_W-1:0]        req_header_byte = '0;
   logic                      req_start_req = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [OCTET_W-1:0]        rsp_first_tag_octet;
   logic [TAG_SIZE_W-1:0]     rsp_tag_size;
   logic [LENGTH_SIZE_W-1:0]  rsp_length_size;
   logic [CONTENT_LEN_W-1:0]  rsp_content_length;
   logic                      rsp_indefinite;

   // decoder state
   hdr_phase_type             hdr_phase = HDR_IDLE;
   logic [2:0]                tag_seen = '0;
   logic [OCTET_W-1:0]        first_octet = '0;
   logic [2:0]                len_left = '0;
   logic [2:0]                len_size = 3'd1;
   logic [CONTENT_LEN_W-1:0]  len_acc = '0;

   result_type                expected_headers[$];
   int                        octets_taken = 0;
   int                        mismatch_count = 0;
   bit                        gaps_on = 1'b1;

   ber_tag_length_header_parser dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_header_byte     (req_header_byte),
      .req_start_req       (req_start_req),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_first_tag_octet (rsp_first_tag_octet),
      .rsp_tag_size        (rsp_tag_size),
      .rsp_length_size     (rsp_length_size),
      .rsp_content_length  (rsp_content_length),
      .rsp_indefinite      (rsp_indefinite)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Result header built from the current first tag octet
   function automatic result_type make_result(input status_type st, input logic [2:0] tsz,
                                              input logic [2:0] lsz,
                                              input logic [31:0] len, input logic indef);
      result_type r;
      r.status          = st;
      r.first_tag_octet = first_octet;
      r.tag_size        = tsz;
      r.length_size     = lsz;
      r.content_length  = len;
      r.indefinite      = indef;
      return r;
   endfunction

   // Advance the header decoder by one octet; flags a finished header or error
   task automatic decode_header_octet(input logic [7:0] b, input logic s,
                                      output bit produced, output result_type res);
      int n;
      int k;
      produced = 1'b0;
      res      = '0;
      if (s) begin
         first_octet = b;
         tag_seen    = 3'd1;
         len_left    = '0;
         len_size    = 3'd1;
         len_acc     = '0;
         if (b == OCTET_ZERO) begin
            res      = make_result(STATUS_BAD_TAG, 3'd0, 3'd0, 32'd0, 1'b0);
            produced = 1'b1;
         end else begin
            hdr_phase = (b[4:0] == TAG_NUM_ESCAPE) ? HDR_TAG_MORE : HDR_LEN_FIRST;
         end
      end else begin
         case (hdr_phase)
            HDR_TAG_MORE: begin
               n = int'(tag_seen) + 1;
               if (n > MAX_TAG_OCTETS_DEF) begin
                  res      = make_result(STATUS_BAD_TAG, 3'd0, 3'd0, 32'd0, 1'b0);
                  produced = 1'b1;
               end else begin
                  tag_seen = 3'(n);
                  if (!b[7]) hdr_phase = HDR_LEN_FIRST;
               end
            end
            HDR_LEN_FIRST: begin
               k = int'(b[6:0] & LEN_COUNT_MASK);
               if (!b[7]) begin
                  res      = make_result(STATUS_OK, tag_seen, 3'd1, {24'd0, b}, 1'b0);
                  produced = 1'b1;
               end else if (b == OCTET_INDEF) begin
                  res      = make_result(STATUS_OK, tag_seen, 3'd1, '1, 1'b1);
                  produced = 1'b1;
               end else if (k > MAX_LENGTH_OCTETS_DEF) begin
                  res      = make_result(STATUS_BAD_LEN, tag_seen, 3'd0, 32'd0, 1'b0);
                  produced = 1'b1;
               end else begin
                  len_left  = 3'(k);
                  len_size  = 3'(k + 1);
                  len_acc   = '0;
                  hdr_phase = HDR_LEN_LONG;
               end
            end
            HDR_LEN_LONG: begin
               len_acc = {len_acc[23:0], b};
               if (len_left > 0) len_left = len_left - 3'd1;
               if (len_left == 0) begin
                  res      = make_result(STATUS_OK, tag_seen, len_size, len_acc, 1'b0);
                  produced = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (produced) hdr_phase = HDR_IDLE;
   endtask

   // Drive one octet beat, wait for it to be taken, then predict
   task automatic send_octet(input logic [7:0] b, input logic s);
      bit         produced;
      result_type res;
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_header_byte <= b;
      req_start_req   <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (s || hdr_phase != HDR_IDLE) octets_taken++;
      decode_header_octet(b, s, produced, res);
      if (produced) expected_headers.push_back(res);
   endtask

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(99) < 24);
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each result beat against the oldest prediction
   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_headers.size() == 0) begin
            $display("%0t: unexpected result beat, status %0h first octet %0h",
                     $time, rsp_status, rsp_first_tag_octet);
            mismatch_count++;
         end else begin
            want = expected_headers.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("first_tag_octet", 32'(want.first_tag_octet),
                        32'(rsp_first_tag_octet));
            check_field("tag_size", 32'(want.tag_size), 32'(rsp_tag_size));
            check_field("length_size", 32'(want.length_size), 32'(rsp_length_size));
            check_field("content_length", want.content_length, rsp_content_length);
            check_field("indefinite", 32'(want.indefinite), 32'(rsp_indefinite));
         end
      end
   end

   // Zero tag, overlong tag, multi-octet tag
   task automatic test_tag_forms();
      send_octet(8'h00, 1'b1);
      send_octet(8'hFF, 1'b1);
      send_octet(8'h81, 1'b0);
      send_octet(8'hFF, 1'b0);
      send_octet(8'hFF, 1'b0);
      send_octet(8'h7E, 1'b0);
      send_octet(8'h1F, 1'b1);
      send_octet(8'h85, 1'b0);
      send_octet(8'h7F, 1'b0);
      send_octet(OCTET_INDEF, 1'b0);
   endtask

   // Short max, widest long form, oversized length count
   task automatic test_length_forms();
      send_octet(8'h04, 1'b1);
      send_octet(8'h7F, 1'b0);
      send_octet(8'h02, 1'b1);
      send_octet(8'h84, 1'b0);
      repeat (4) send_octet(8'hFF, 1'b0);
      send_octet(8'h30, 1'b1);
      send_octet(8'hFF, 1'b0);
   endtask

   // Octets with no header open, and a restart in the middle of a length
   task automatic test_idle_and_restart();
      send_octet(8'h55, 1'b0);
      send_octet(8'h30, 1'b1);
      send_octet(8'h82, 1'b0);
      send_octet(8'h01, 1'b0);
      send_octet(8'h31, 1'b1);
      send_octet(8'h81, 1'b0);
      send_octet(8'h00, 1'b0);
   endtask

   // One random header: mostly well formed, some noise and broken ones
   task automatic send_random_header();
      int         pick;
      int         ncont;
      int         k;
      logic [7:0] b;
      pick = $urandom_range(99);
      if (pick < 8) begin
         repeat ($urandom_range(1, 3))
            send_octet(8'($urandom_range(255)), $urandom_range(99) < 30);
      end else if (pick < 12) begin
         send_octet(OCTET_ZERO, 1'b1);
      end else begin
         b = 8'($urandom_range(1, 255));
         if ($urandom_range(99) < 35) b[4:0] = TAG_NUM_ESCAPE;
         send_octet(b, 1'b1);
         if (b[4:0] == TAG_NUM_ESCAPE) begin
            if ($urandom_range(99) < 12) begin
               // overlong tag: continuation octets keep bit 7 set until the tag limit is hit
               repeat (MAX_TAG_OCTETS_DEF - 1) send_octet(8'($urandom_range(255)) | 8'h80, 1'b0);
               send_octet(8'($urandom_range(255)), 1'b0);
               return;
            end
            ncont = $urandom_range(1, MAX_TAG_OCTETS_DEF - 1);
            for (int i = 0; i < ncont; i++) begin
               b    = 8'($urandom_range(255));
               b[7] = (i < ncont - 1);
               send_octet(b, 1'b0);
            end
         end
         // abandoned header, the next start takes over
         if ($urandom_range(99) < 6) return;
         pick = $urandom_range(99);
         if (pick < 35) begin
            send_octet(8'($urandom_range(127)), 1'b0);
         end else if (pick < 45) begin
            send_octet(OCTET_INDEF, 1'b0);
         end else if (pick < 55) begin
            k = $urandom_range(MAX_LENGTH_OCTETS_DEF + 1, 127);
            send_octet(8'h80 | 8'(k), 1'b0);
         end else begin
            k = $urandom_range(1, MAX_LENGTH_OCTETS_DEF);
            send_octet(8'h80 | 8'(k), 1'b0);
            repeat (k) send_octet(8'($urandom_range(255)), 1'b0);
         end
      end
   endtask

   task automatic test_random_headers();
      octets_taken = 0;
      while (octets_taken < RANDOM_OCTETS) begin
         // a stretch with no idling on either side
         gaps_on = !(octets_taken >= 350 && octets_taken < 500);
         send_random_header();
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_tag_forms();
      test_length_forms();
      test_idle_and_restart();
      test_random_headers();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_headers.size() == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
